// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rptr_pkg.sv -----
// Package: constants, register codes and shared types of the pulse timing recorder.
package rptr_pkg;

	localparam int MAX_EDGES = 64;
	localparam int ADDR_W    = $clog2(MAX_EDGES);
	localparam int EC_W      = $clog2(MAX_EDGES + 1);

	localparam int TS_W   = 16;
	localparam int DUR_W  = 17;
	localparam int RC_W   = 4;
	localparam int IDX_W  = 6;
	localparam int FE_W   = 7;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_SEP_LIMIT  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_GAP_TOL    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_REPEAT_THR = 2'd2;

	localparam logic [DUR_W-1:0] SEP_LIMIT_RST  = 17'd4300;
	localparam logic [DUR_W-1:0] GAP_TOL_RST    = 17'd200;
	localparam logic [RC_W-1:0]  REPEAT_THR_RST = 4'd2;

	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic [DUR_W-1:0] sep_limit;
		logic [DUR_W-1:0] gap_tol;
		logic [RC_W-1:0]  repeat_thr;
	} cfg_t;

	typedef struct packed {
		logic              frame_ready;
		logic [FE_W-1:0]   frame_edges;
		logic [ADDR_W-1:0] wr_addr;
	} trk_t;

endpackage

// ----- rtl/core/rptr_timing_ram.sv -----
// Timing store: one write port, one registered read port.
module rptr_timing_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [rptr_pkg::ADDR_W-1:0] waddr,
	input  logic [rptr_pkg::DUR_W-1:0]  wdata,
	input  logic                       re,
	input  logic [rptr_pkg::ADDR_W-1:0] raddr,
	output logic [rptr_pkg::DUR_W-1:0]  rdata
);
	import rptr_pkg::*;

	logic [DUR_W-1:0] mem [MAX_EDGES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/rptr_gap_track.sv -----
// Gap detection, repeat and edge counters, and store address for each capture.
module rptr_gap_track (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       commit,
	input  logic [rptr_pkg::DUR_W-1:0]  dur,
	input  rptr_pkg::cfg_t             cfg,
	output rptr_pkg::trk_t             trk
);
	import rptr_pkg::*;

	logic [RC_W-1:0]  repeat_count_q;
	logic [EC_W-1:0]  edge_count_q;
	logic [DUR_W-1:0] entry0_q;

	logic             is_gap;
	logic [DUR_W-1:0] adiff;
	logic             match;
	logic [RC_W-1:0]  rc_inc;
	logic             hit;
	logic [RC_W-1:0]  rc_a;
	logic [EC_W-1:0]  ec_a;
	logic             full;
	logic [RC_W-1:0]  rc_n;
	logic [EC_W-1:0]  ec_w;

	always_comb begin
		is_gap = dur > cfg.sep_limit;
		adiff  = (dur >= entry0_q) ? (dur - entry0_q) : (entry0_q - dur);
		match  = (repeat_count_q == '0) || (adiff < cfg.gap_tol);
		rc_inc = repeat_count_q + RC_W'(1);
		hit    = is_gap && match && (rc_inc == cfg.repeat_thr);
		rc_a   = (is_gap && match) ? (hit ? '0 : rc_inc) : repeat_count_q;
		ec_a   = is_gap ? '0 : edge_count_q;
		full   = ec_a >= EC_W'(MAX_EDGES);
		rc_n   = full ? '0 : rc_a;
		ec_w   = full ? '0 : ec_a;
		trk.frame_ready = hit;
		trk.frame_edges = hit ? FE_W'(edge_count_q) : '0;
		trk.wr_addr     = ADDR_W'(ec_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_count_q <= '0;
			edge_count_q   <= '0;
		end else if (commit) begin
			repeat_count_q <= rc_n;
			edge_count_q   <= ec_w + EC_W'(1);
		end
	end

	// hold a copy of entry 0 for the gap match
	always_ff @(posedge clk) begin
		if (commit && ec_w == '0) begin
			entry0_q <= dur;
		end
	end

endmodule

// ----- rtl/core/rf_pulse_timing_recorder.sv -----
// Top level of the pulse timing recorder: capture pipeline, registers and output stage.
// An input beat passes through the stage 1 and stage 2 registers to the output beat.
// Throughput: one beat per cycle unless stalled; the store takes one write or read per cycle.
// Duration is computed in stage 1; gap tracking, store write and store read in stage 2.
// Reset: counters and last capture clear, registers take their defaults; store is not cleared.
module rf_pulse_timing_recorder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rptr_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [rptr_pkg::DUR_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [rptr_pkg::TS_W-1:0]    capture_value,
	input  logic [rptr_pkg::IDX_W-1:0]   read_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rptr_pkg::DUR_W-1:0]   pulse_duration,
	output logic                         frame_ready,
	output logic [rptr_pkg::FE_W-1:0]    frame_edges,
	output logic [rptr_pkg::DUR_W-1:0]   read_value
);
	import rptr_pkg::*;

	cfg_t cfg_q;

	logic [TS_W-1:0]   last_q;
	logic [TS_W-1:0]   diff;
	logic [DUR_W:0]    triple;

	logic              valid_s1;
	logic              op_s1;
	logic              inrange_s1;
	logic [DUR_W-1:0]  dur_s1;
	logic [ADDR_W-1:0] raddr_s1;

	logic              valid_s2;
	logic              op_s2;
	logic              inrange_s2;
	logic [DUR_W-1:0]  dur_s2;
	logic              ready_s2;
	logic [FE_W-1:0]   edges_s2;

	logic              adv;
	logic              take;
	logic              commit;
	logic              rd_en;
	logic [DUR_W-1:0]  rdata;
	trk_t              trk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep_limit  <= SEP_LIMIT_RST;
			cfg_q.gap_tol    <= GAP_TOL_RST;
			cfg_q.repeat_thr <= REPEAT_THR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEP_LIMIT:  cfg_q.sep_limit  <= cfg_data;
				REG_GAP_TOL:    cfg_q.gap_tol    <= cfg_data;
				REG_REPEAT_THR: cfg_q.repeat_thr <= cfg_data[RC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign take     = in_valid && in_ready;
	assign commit   = adv && valid_s1 && (op_s1 == OP_CAPTURE);
	assign rd_en    = adv && valid_s1 && (op_s1 == OP_READ);

	// scale by 3/2: (diff + 2*diff) >> 1
	assign diff   = capture_value - last_q;
	assign triple = {2'b00, diff} + {1'b0, diff, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take && op == OP_CAPTURE) begin
				last_q <= capture_value;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1      <= op;
			dur_s1     <= triple[DUR_W:1];
			inrange_s1 <= 32'(read_index) < 32'(MAX_EDGES);
			raddr_s1   <= ADDR_W'(read_index);
		end
	end

	rptr_gap_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.dur    (dur_s1),
		.cfg    (cfg_q),
		.trk    (trk)
	);

	rptr_timing_ram u_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (trk.wr_addr),
		.wdata (dur_s1),
		.re    (rd_en),
		.raddr (raddr_s1),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			op_s2      <= op_s1;
			inrange_s2 <= inrange_s1;
			dur_s2     <= dur_s1;
			ready_s2   <= commit && trk.frame_ready;
			edges_s2   <= commit ? trk.frame_edges : '0;
		end
	end

	assign out_valid      = valid_s2;
	assign pulse_duration = (op_s2 == OP_CAPTURE) ? dur_s2 : '0;
	assign frame_ready    = (op_s2 == OP_CAPTURE) && ready_s2;
	assign frame_edges    = (op_s2 == OP_CAPTURE) ? edges_s2 : '0;
	assign read_value     = (op_s2 == OP_READ && inrange_s2) ? rdata : '0;

endmodule

// ----- rtl/core/rptr_checker.sv -----
// Port-level checker for the pulse timing recorder, bound to the top level.
`include "assert_macros.svh"

module rptr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [rptr_pkg::CIDX_W-1:0]  cfg_index,
	input logic [rptr_pkg::DUR_W-1:0]   cfg_data,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         op,
	input logic [rptr_pkg::TS_W-1:0]    capture_value,
	input logic [rptr_pkg::IDX_W-1:0]   read_index,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rptr_pkg::DUR_W-1:0]   pulse_duration,
	input logic                         frame_ready,
	input logic [rptr_pkg::FE_W-1:0]    frame_edges,
	input logic [rptr_pkg::DUR_W-1:0]   read_value
);
	import rptr_pkg::*;

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(pulse_duration) && $stable(read_value) && $stable(frame_edges), "output beat changed while stalled")
	`ASSERT_CLK(a_read_excl, clk, arst_n, out_valid && read_value != '0 |-> pulse_duration == '0 && !frame_ready, "read beat carries capture fields")
	`ASSERT_CLK(a_edges_zero, clk, arst_n, out_valid && !frame_ready |-> frame_edges == '0, "frame edges without frame ready")
	`ASSERT_CLK(a_ready_gap, clk, arst_n, out_valid && frame_ready |-> pulse_duration != '0, "frame ready on a zero duration")
	`ASSERT_ALWAYS(a_cfg_rdy, clk, !arst_n || cfg_ready, "configuration port not ready")

endmodule

bind rf_pulse_timing_recorder rptr_checker u_rptr_checker (.*);

// ----- tb/sv/rf_pulse_timing_recorder_tb.sv -----
// Testbench for rf_pulse_timing_recorder: random and directed captures and reads checked by a scoreboard.
`timescale 1ns / 100ps

module rf_pulse_timing_recorder_tb;
	import rptr_pkg::*;

	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic             ready;
		logic [FE_W-1:0]  edges;
		logic [DUR_W-1:0] value;
	} frame_result_t;

	class edge_timing_scoreboard;
		cfg_t             cfg;
		logic [TS_W-1:0]  last_ts;
		logic [RC_W-1:0]  repeats;
		logic [FE_W-1:0]  edge_cnt;
		logic [DUR_W-1:0] durations [MAX_EDGES];
		bit               written [MAX_EDGES];
		frame_result_t    pending_results [$];
		int               errors;

		function new();
			cfg.sep_limit = SEP_LIMIT_RST;
			cfg.gap_tol = GAP_TOL_RST;
			cfg.repeat_thr = REPEAT_THR_RST;
			last_ts = '0;
			repeats = '0;
			edge_cnt = '0;
			errors = 0;
			for (int i = 0; i < MAX_EDGES; i++) begin
				durations[i] = '0;
				written[i] = 1'b0;
			end
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, logic [DUR_W-1:0] data);
			case (idx)
				REG_SEP_LIMIT: begin
					cfg.sep_limit = data;
				end
				REG_GAP_TOL: begin
					cfg.gap_tol = data;
				end
				REG_REPEAT_THR: begin
					cfg.repeat_thr = data[RC_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_beat(logic kind, logic [TS_W-1:0] ts, logic [IDX_W-1:0] idx);
			frame_result_t res;
			logic [TS_W-1:0] diff;
			int unsigned d, scaled, a, b, gap_diff;
			res = '0;
			if (kind == OP_READ) begin
				res.value = durations[idx];
				pending_results.push_back(res);
				return;
			end
			diff = ts - last_ts;
			last_ts = ts;
			d = diff;
			scaled = (d * 3) / 2;
			res.duration = scaled[DUR_W-1:0];
			if (res.duration > cfg.sep_limit) begin
				a = res.duration;
				b = durations[0];
				gap_diff = (a >= b) ? a - b : b - a;
				if (repeats == '0 || gap_diff < cfg.gap_tol) begin
					repeats = repeats + 1'b1;
					if (repeats == cfg.repeat_thr) begin
						res.ready = 1'b1;
						res.edges = edge_cnt;
						repeats = '0;
					end
				end
				edge_cnt = '0;
			end
			if (edge_cnt >= MAX_EDGES) begin
				edge_cnt = '0;
				repeats = '0;
			end
			durations[edge_cnt[ADDR_W-1:0]] = res.duration;
			written[edge_cnt[ADDR_W-1:0]] = 1'b1;
			edge_cnt = edge_cnt + 1'b1;
			pending_results.push_back(res);
		endfunction

		function void check_beat(logic [DUR_W-1:0] dur, logic rdy, logic [FE_W-1:0] fe,
				logic [DUR_W-1:0] rv);
			frame_result_t want;
			if (pending_results.size() == 0) begin
				$error("result beat with no input beat waiting");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (dur !== want.duration) begin
				$error("pulse_duration: expected %0d, got %0d", want.duration, dur);
				errors++;
			end
			if (rdy !== want.ready) begin
				$error("frame_ready: expected %0d, got %0d", want.ready, rdy);
				errors++;
			end
			if (fe !== want.edges) begin
				$error("frame_edges: expected %0d, got %0d", want.edges, fe);
				errors++;
			end
			if (rv !== want.value) begin
				$error("read_value: expected %0d, got %0d", want.value, rv);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function int pick_written();
			int slots [$];
			for (int i = 0; i < MAX_EDGES; i++) begin
				if (written[i]) begin
					slots.push_back(i);
				end
			end
			if (slots.size() == 0) begin
				return -1;
			end
			return slots[$urandom_range(0, slots.size() - 1)];
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [DUR_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = OP_CAPTURE;
	logic [TS_W-1:0]   capture_value = '0;
	logic [IDX_W-1:0]  read_index = '0;
	logic              out_valid;
	logic              out_ready = 1'b1;
	logic [DUR_W-1:0]  pulse_duration;
	logic              frame_ready;
	logic [FE_W-1:0]   frame_edges;
	logic [DUR_W-1:0]  read_value;

	edge_timing_scoreboard sb;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int beats_sent = 0;
	int idle_cycles = 0;

	rf_pulse_timing_recorder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.capture_value  (capture_value),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pulse_duration (pulse_duration),
		.frame_ready    (frame_ready),
		.frame_edges    (frame_edges),
		.read_value     (read_value)
	);

	always #10 clk = ~clk;

	always begin
		@(posedge clk);
		if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_beat(pulse_duration, frame_ready, frame_edges, read_value);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_beat(input logic kind, input logic [TS_W-1:0] ts,
			input logic [IDX_W-1:0] idx);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		capture_value <= ts;
		read_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(kind, ts, idx);
		beats_sent++;
	endtask

	task automatic send_capture(input int ticks);
		logic [TS_W-1:0] ts;
		ts = sb.last_ts + ticks[TS_W-1:0];
		send_beat(OP_CAPTURE, ts, IDX_W'($urandom));
	endtask

	task automatic send_read();
		int slot;
		slot = sb.pick_written();
		if (slot >= 0) begin
			send_beat(OP_READ, TS_W'($urandom), slot[IDX_W-1:0]);
		end
	endtask

	function automatic int pulse_ticks();
		int hi;
		hi = sb.cfg.sep_limit * 2 / 3;
		if (hi > 3000) begin
			hi = 3000;
		end
		return $urandom_range(0, hi);
	endfunction

	task automatic send_frames();
		int reps, pulses, base, gap;
		bit long_frames;
		long_frames = ($urandom_range(0, 7) == 0);
		if (long_frames) begin
			reps = $urandom_range(1, 3);
		end else if ($urandom_range(0, 3) == 0) begin
			reps = $urandom_range(12, 18);
		end else begin
			reps = $urandom_range(1, 5);
		end
		base = sb.cfg.sep_limit * 2 / 3 + $urandom_range(1, 6000);
		if (base > 65535) begin
			base = 65535;
		end
		repeat (reps) begin
			if ($urandom_range(0, 4) == 0) begin
				gap = base + int'($urandom_range(0, 4000)) - 2000;
			end else begin
				gap = base + int'($urandom_range(0, 160)) - 80;
			end
			if (gap < 0) begin
				gap = 0;
			end else if (gap > 65535) begin
				gap = 65535;
			end
			send_capture(gap);
			pulses = long_frames ? $urandom_range(50, 70) : $urandom_range(0, 8);
			repeat (pulses) begin
				send_capture(pulse_ticks());
				if ($urandom_range(0, 15) == 0) begin
					send_read();
				end
			end
		end
	endtask

	task automatic run_traffic(input int count);
		int stop, kind;
		stop = beats_sent + count;
		while (beats_sent < stop) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_frames();
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 4)) send_read();
			end else begin
				repeat ($urandom_range(1, 3)) send_beat(OP_CAPTURE, TS_W'($urandom),
					IDX_W'($urandom));
			end
		end
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [DUR_W-1:0] sep, input logic [DUR_W-1:0] tol,
			input logic [RC_W-1:0] thr);
		logic [DUR_W-1:0]  vals [3];
		logic [CIDX_W-1:0] regs [3];
		vals[0] = sep;
		vals[1] = tol;
		vals[2] = DUR_W'(thr);
		regs[0] = REG_SEP_LIMIT;
		regs[1] = REG_GAP_TOL;
		regs[2] = REG_REPEAT_THR;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [DUR_W-1:0] sep, input logic [DUR_W-1:0] tol,
			input logic [RC_W-1:0] thr, input int count, input bit idle);
		drain_pipe();
		write_regs(sep, tol, thr);
		tx_idle_on = idle;
		rx_idle_on = idle;
		run_traffic(count);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_capture(0);
		send_beat(OP_READ, '1, '0);
		send_capture(65535);
		send_capture(17);
		send_capture(65535);
		send_beat(OP_READ, '0, 6'd0);
		send_beat(OP_READ, '1, 6'd1);
		send_capture(2867);
		send_capture(2868);
		send_capture(0);
		send_capture(2868);
		send_beat(OP_READ, '0, 6'd1);
		send_capture(3001);
		send_capture(3134);
		send_capture(3134);
		send_beat(OP_READ, '1, 6'd0);

		run_phase(17'd131071, 17'd0, 4'd1, 150, 1'b1);
		run_phase(17'd0, 17'd131071, 4'd15, 150, 1'b1);
		run_phase(17'd0, 17'd0, 4'd1, 150, 1'b0);

		drain_pipe();
		write_regs(SEP_LIMIT_RST, GAP_TOL_RST, 4'd0);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (17) begin
			send_capture(10000);
			send_capture(100);
		end
		run_traffic(150);

		for (int p = 0; p < 5; p++) begin
			if (p == 4) begin
				run_phase(DUR_W'($urandom_range(0, 131071)), DUR_W'($urandom_range(0, 131071)),
					RC_W'($urandom_range(0, 15)), 150, 1'b1);
			end else begin
				run_phase(DUR_W'($urandom_range(500, 30000)), DUR_W'($urandom_range(0, 1500)),
					RC_W'($urandom_range(0, 15)), 150, p != 2);
			end
		end

		run_phase(SEP_LIMIT_RST, GAP_TOL_RST, REPEAT_THR_RST, 200, 1'b0);
		drain_pipe();
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
